FILE: sv/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants for the CIGAR string parser
// Character codes, operation codes, the command passed from the front end
// to the back end, and the result record.
// ----------------------------------------------------------------------------
package csp_pkg;

  localparam int LEN_W = 31;
  typedef logic [LEN_W-1:0] len_t;
  localparam len_t LEN_MAX = '1;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_M    = 8'h4D;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_X    = 8'h58;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_N    = 8'h4E;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_M    = 4'd1,
    OP_EQ   = 4'd2,
    OP_X    = 4'd3,
    OP_INS  = 4'd4,
    OP_DEL  = 4'd5,
    OP_SKIP = 4'd6,
    OP_SOFT = 4'd7,
    OP_HARD = 4'd8
  } op_t;

  // Command from front end to back end
  typedef struct packed {
    logic        first;
    logic [31:0] origin;
    logic        last;
    logic        rec;
    logic        star;
    op_t         code;
    len_t        len;
  } cmd_t;

  // One result record
  typedef struct packed {
    logic        kind;
    op_t         code;
    len_t        len;
    logic        read_used;
    logic [31:0] read_start;
    logic        ref_used;
    logic [31:0] ref_start;
    logic [31:0] read_length;
    len_t        match_total;
    len_t        insert_total;
    len_t        delete_total;
    len_t        clip_total;
  } res_t;

  function automatic op_t char_to_op(input logic [7:0] c);
    op_t op;
    unique case (c)
      CH_M:    op = OP_M;
      CH_EQ:   op = OP_EQ;
      CH_X:    op = OP_X;
      CH_I:    op = OP_INS;
      CH_D:    op = OP_DEL;
      CH_N:    op = OP_SKIP;
      CH_S:    op = OP_SOFT;
      CH_H:    op = OP_HARD;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic op_on_read(input op_t op);
    return (op == OP_M) || (op == OP_EQ) || (op == OP_X) || (op == OP_INS) ||
           (op == OP_SOFT) || (op == OP_HARD);
  endfunction

  function automatic logic op_on_ref(input op_t op);
    return (op == OP_M) || (op == OP_EQ) || (op == OP_X) || (op == OP_DEL) ||
           (op == OP_SKIP);
  endfunction

  function automatic len_t sat_add(input len_t a, input len_t b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LEN_W-1:0];
  endfunction

endpackage

FILE: sv/csp_front.sv
// ----------------------------------------------------------------------------
// csp_front: character intake and classification
// Accumulates decimal run lengths, tracks the star stop flag, and turns each
// character into a command for the back end when it has work to do.
// ----------------------------------------------------------------------------
module csp_front
  import csp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        first,
  input  logic [31:0] origin,
  input  logic        last,
  input  logic        full,
  output logic        push,
  output cmd_t        cmd
);

  localparam int PROD_W = LEN_W + 4;

  len_t              number_acc, number_acc_next;
  logic              stopped, stopped_next;
  logic              acc;
  logic              stop_eff;
  len_t              acc_eff;
  op_t               code;
  logic              is_digit;
  logic [PROD_W-1:0] prod;

  assign in_ready = !full;
  assign acc      = in_valid && in_ready;

  always_comb begin
    stop_eff        = first ? 1'b0 : stopped;
    acc_eff         = first ? '0 : number_acc;
    code            = char_to_op(ch);
    is_digit        = (ch >= CH_ZERO) && (ch <= CH_NINE);
    prod            = ({4'b0, acc_eff} << 3) + ({4'b0, acc_eff} << 1) +
                      PROD_W'(ch[3:0]);
    number_acc_next = acc_eff;
    stopped_next    = stop_eff;
    cmd.first       = first;
    cmd.origin      = origin;
    cmd.last        = last;
    cmd.rec         = 1'b0;
    cmd.star        = 1'b0;
    cmd.code        = OP_NONE;
    cmd.len         = '0;
    if (!stop_eff) begin
      priority if (is_digit) begin
        number_acc_next = (prod > PROD_W'(LEN_MAX)) ? LEN_MAX : prod[LEN_W-1:0];
      end else if (ch == CH_STAR) begin
        stopped_next = 1'b1;
        cmd.rec      = 1'b1;
        cmd.star     = 1'b1;
      end else if (ch == CH_P) begin
        number_acc_next = '0;
      end else if (code != OP_NONE) begin
        cmd.rec         = 1'b1;
        cmd.code        = code;
        cmd.len         = acc_eff;
        number_acc_next = '0;
      end else begin
        // unknown character: keep pending digits
        number_acc_next = acc_eff;
      end
    end
  end

  assign push = acc && (first || last || cmd.rec);

  always_ff @(posedge clk) begin
    if (rst) begin
      number_acc <= '0;
      stopped    <= 1'b0;
    end else if (acc) begin
      number_acc <= number_acc_next;
      stopped    <= stopped_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_begin_clears_stop: assert property (@(posedge clk) disable iff (rst)
    (acc && first && ch != CH_STAR) |=> !stopped)
    else $error("stop flag survived a new string");
`endif

endmodule

FILE: sv/csp_queue.sv
// ----------------------------------------------------------------------------
// csp_queue: command queue between front end and back end
// Four-entry FIFO so that intake and record output stall independently.
// ----------------------------------------------------------------------------
module csp_queue
  import csp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  input  logic pop,
  output cmd_t head,
  output logic full,
  output logic empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (full |-> !push) and (empty |-> !pop))
    else $error("command queue overflow or underflow");
`endif

endmodule

FILE: sv/csp_back.sv
// ----------------------------------------------------------------------------
// csp_back: command execution and record output
// Keeps read and reference positions and the running totals, builds the
// operation and summary records, and holds them in the output register.
// ----------------------------------------------------------------------------
module csp_back
  import csp_pkg::*;
#(
  parameter int POS_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  cmd_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t res
);

  logic [POS_WIDTH-1:0] read_pos, ref_pos;
  logic [POS_WIDTH-1:0] base_rp, base_fp, rp_next, fp_next;
  len_t                 match_sum, insert_sum, delete_sum, clip_sum;
  len_t                 match_next, insert_next, delete_next, clip_next;
  logic                 phase, phase_next;
  logic                 out_free, needs_out, fire, emit_summary, hold_cmd;
  logic                 nz, rdu, rfu;
  res_t                 res_next;

  assign out_free     = !out_valid || out_ready;
  assign needs_out    = phase || head.rec || head.last;
  assign fire         = !empty && (!needs_out || out_free);
  assign emit_summary = phase || (!head.rec && head.last);
  // keep the command at the head while its summary is still owed
  assign hold_cmd     = !phase && head.rec && head.last;
  assign pop          = fire && !hold_cmd;
  assign phase_next   = fire ? hold_cmd : phase;

  always_comb begin
    if (!phase && head.first) begin
      base_rp     = '0;
      base_fp     = POS_WIDTH'(head.origin);
      match_next  = '0;
      insert_next = '0;
      delete_next = '0;
      clip_next   = '0;
    end else begin
      base_rp     = read_pos;
      base_fp     = ref_pos;
      match_next  = match_sum;
      insert_next = insert_sum;
      delete_next = delete_sum;
      clip_next   = clip_sum;
    end
    rp_next = base_rp;
    fp_next = base_fp;
    nz      = (head.len != '0);
    rdu     = 1'b0;
    rfu     = 1'b0;
    if (!phase && head.rec) begin
      if (head.star) begin
        match_next  = '0;
        insert_next = '0;
        delete_next = '0;
        clip_next   = '0;
      end else begin
        rdu = op_on_read(head.code) && nz;
        rfu = op_on_ref(head.code) && nz;
        if (rdu) begin
          rp_next = base_rp + POS_WIDTH'(head.len);
        end
        if (rfu) begin
          fp_next = base_fp + POS_WIDTH'(head.len);
        end
        unique case (head.code)
          OP_M, OP_EQ, OP_X: match_next  = sat_add(match_next, head.len);
          OP_INS:            insert_next = sat_add(insert_next, head.len);
          OP_DEL:            delete_next = sat_add(delete_next, head.len);
          OP_SOFT, OP_HARD:  clip_next   = sat_add(clip_next, head.len);
          default:           ;
        endcase
      end
    end

    res_next.kind         = emit_summary;
    res_next.code         = emit_summary ? OP_NONE : head.code;
    res_next.len          = emit_summary ? '0 : head.len;
    res_next.read_used    = !emit_summary && rdu;
    res_next.read_start   = (!emit_summary && rdu) ? 32'(base_rp) : '0;
    res_next.ref_used     = !emit_summary && rfu;
    res_next.ref_start    = (!emit_summary && rfu) ? 32'(base_fp) : '0;
    res_next.read_length  = 32'(rp_next);
    res_next.match_total  = match_next;
    res_next.insert_total = insert_next;
    res_next.delete_total = delete_next;
    res_next.clip_total   = clip_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pos   <= '0;
      ref_pos    <= '0;
      match_sum  <= '0;
      insert_sum <= '0;
      delete_sum <= '0;
      clip_sum   <= '0;
      phase      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        read_pos   <= rp_next;
        ref_pos    <= fp_next;
        match_sum  <= match_next;
        insert_sum <= insert_next;
        delete_sum <= delete_next;
        clip_sum   <= clip_next;
      end
      phase <= phase_next;
      if (fire && needs_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && needs_out) begin
      res <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_phase_has_cmd: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!empty && head.rec && head.last))
    else $error("summary pending without its command");
  a_quiet_cmd_pops: assert property (@(posedge clk) disable iff (rst)
    (fire && !needs_out) |-> pop)
    else $error("command without output not retired");
  a_summary_follows: assert property (@(posedge clk) disable iff (rst)
    (fire && hold_cmd) |=> phase)
    else $error("summary step skipped");
`endif

endmodule

FILE: sv/cigar_string_parser.sv
// A record passes through the command queue and then the output register; a summary
// after an operation record of the same item follows it from the same queue entry.
// Throughput: one item per cycle while the command queue is not full; such an item
// yields two records from the output register in turn. Output rate is set by the back end.
// Reset (synchronous, active high) clears positions, totals, the pending run
// length, the stop flag and the command queue.
// ----------------------------------------------------------------------------
// cigar_string_parser: SAM CIGAR string parser
// Reads one CIGAR character per item and emits per-operation records with
// read/reference start positions and running totals, plus a summary record.
// ----------------------------------------------------------------------------
module cigar_string_parser
  import csp_pkg::*;
#(
  parameter int POS_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,  // ch[7:0], ref_origin[39:8]
  input  logic         s_tuser,  // begin_string
  input  logic         s_tlast,  // end_string
  output logic         m_tvalid,
  input  logic         m_tready,
  // op_code[3:0], op_len[34:4], read_used[35], read_start[67:36],
  // ref_used[68], ref_start[100:69], read_length[132:101],
  // match_total[163:133], insert_total[194:164], delete_total[225:195],
  // clip_total[256:226], zero pad[263:257]
  output logic [263:0] m_tdata,
  output logic         m_tuser   // kind
);

  cmd_t wr_cmd, head;
  logic push, pop, full, empty;
  res_t res;

  csp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .ch       (s_tdata[7:0]),
    .first    (s_tuser),
    .origin   (s_tdata[39:8]),
    .last     (s_tlast),
    .full     (full),
    .push     (push),
    .cmd      (wr_cmd)
  );

  csp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .head   (head),
    .full   (full),
    .empty  (empty)
  );

  csp_back #(
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {7'b0, res.clip_total, res.delete_total, res.insert_total,
                    res.match_total, res.read_length, res.ref_start, res.ref_used,
                    res.read_start, res.read_used, res.len, res.code};

endmodule

FILE: dv/tb_cigar_string_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cigar_string_parser: self-checking bench for the CIGAR string parser
// Streams CIGAR strings one character per item and predicts every operation
// and summary record in the bench itself. A short directed string set comes
// first, then random strings under four idle/stall mixes and one long output
// hold-off, and each record is checked field by field.
// ----------------------------------------------------------------------------
module tb_cigar_string_parser;
  import csp_pkg::*;

  typedef struct {
    logic [7:0]  ch;
    logic        first;
    logic [31:0] origin;
    logic        last;
  } cigar_char_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [39:0]  s_tdata = '0;   // ch[7:0], ref_origin[39:8]
  logic         s_tuser = 1'b0; // begin_string
  logic         s_tlast = 1'b0; // end_string
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [263:0] m_tdata;        // op_code .. clip_total, see the block's port list
  logic         m_tuser;        // kind

  cigar_string_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  cigar_char_t pending_chars[$];
  res_t        expected_records[$];
  cigar_char_t offered;
  bit          offer_held = 1'b0;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  int n_queued = 0;
  int n_strings = 0;
  int n_taken = 0;
  int n_op_records = 0;
  int n_summaries = 0;
  int n_input_stalls = 0;
  int n_errors = 0;

  // Predictor state
  logic [31:0] read_cursor = '0;
  logic [31:0] ref_cursor = '0;
  len_t        run_len = '0;
  logic        star_seen = 1'b0;
  len_t        match_acc = '0;
  len_t        insert_acc = '0;
  len_t        delete_acc = '0;
  len_t        clip_acc = '0;

  function automatic len_t capped_sum(input len_t a, input len_t b);
    logic [31:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31] ? LEN_MAX : s[30:0];
  endfunction

  task automatic push_record(input logic kind, input op_t code, input len_t len,
                             input logic rdu, input logic [31:0] rds,
                             input logic rfu, input logic [31:0] rfs);
    res_t r;
    r.kind         = kind;
    r.code         = code;
    r.len          = len;
    r.read_used    = rdu;
    r.read_start   = rds;
    r.ref_used     = rfu;
    r.ref_start    = rfs;
    r.read_length  = read_cursor;
    r.match_total  = match_acc;
    r.insert_total = insert_acc;
    r.delete_total = delete_acc;
    r.clip_total   = clip_acc;
    expected_records.insert(expected_records.size(), r);
  endtask

  // Advance the parser state by one character and queue the records it causes
  task automatic parse_char(input cigar_char_t it);
    op_t         code;
    logic        on_read, on_ref, rdu, rfu;
    logic [31:0] rds, rfs;
    logic [63:0] v;
    len_t        len;
    if (it.first) begin
      read_cursor = '0;
      ref_cursor  = it.origin;
      run_len     = '0;
      star_seen   = 1'b0;
      match_acc   = '0;
      insert_acc  = '0;
      delete_acc  = '0;
      clip_acc    = '0;
    end
    if (!star_seen) begin
      code    = OP_NONE;
      on_read = 1'b0;
      on_ref  = 1'b0;
      case (it.ch)
        CH_M: begin
          code = OP_M; on_read = 1'b1; on_ref = 1'b1;
        end
        CH_EQ: begin
          code = OP_EQ; on_read = 1'b1; on_ref = 1'b1;
        end
        CH_X: begin
          code = OP_X; on_read = 1'b1; on_ref = 1'b1;
        end
        CH_I: begin
          code = OP_INS; on_read = 1'b1;
        end
        CH_D: begin
          code = OP_DEL; on_ref = 1'b1;
        end
        CH_N: begin
          code = OP_SKIP; on_ref = 1'b1;
        end
        CH_S: begin
          code = OP_SOFT; on_read = 1'b1;
        end
        CH_H: begin
          code = OP_HARD; on_read = 1'b1;
        end
        default: ;
      endcase
      if (it.ch >= CH_ZERO && it.ch <= CH_NINE) begin
        v = 64'(run_len) * 64'd10 + 64'(it.ch - CH_ZERO);
        run_len = (v > 64'(LEN_MAX)) ? LEN_MAX : v[30:0];
      end else if (it.ch == CH_STAR) begin
        match_acc  = '0;
        insert_acc = '0;
        delete_acc = '0;
        clip_acc   = '0;
        star_seen  = 1'b1;
        push_record(1'b0, OP_NONE, '0, 1'b0, '0, 1'b0, '0);
      end else if (it.ch == CH_P) begin
        run_len = '0;
      end else if (code != OP_NONE) begin
        len = run_len;
        rdu = on_read && (len != 0);
        rfu = on_ref && (len != 0);
        rds = rdu ? read_cursor : '0;
        rfs = rfu ? ref_cursor : '0;
        if (rdu) read_cursor = read_cursor + 32'(len);
        if (rfu) ref_cursor = ref_cursor + 32'(len);
        case (code)
          OP_M, OP_EQ, OP_X: match_acc = capped_sum(match_acc, len);
          OP_INS:            insert_acc = capped_sum(insert_acc, len);
          OP_DEL:            delete_acc = capped_sum(delete_acc, len);
          OP_SOFT, OP_HARD:  clip_acc = capped_sum(clip_acc, len);
          default: ;
        endcase
        run_len = '0;
        push_record(1'b0, code, len, rdu, rds, rfu, rfs);
      end
    end
    if (it.last) push_record(1'b1, OP_NONE, '0, 1'b0, '0, 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (n_errors < 40)
      $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic queue_char(input logic [7:0] ch, input logic first,
                            input logic [31:0] origin, input logic last);
    cigar_char_t c;
    c.ch     = ch;
    c.first  = first;
    c.origin = origin;
    c.last   = last;
    pending_chars.insert(pending_chars.size(), c);
    n_queued++;
  endtask

  task automatic queue_text(input string text, input logic [31:0] origin);
    for (int i = 0; i < text.len(); i++)
      queue_char(text[i], i == 0, origin, i == text.len() - 1);
    n_strings++;
  endtask

  // Mostly well-formed strings with random content; the rest is noise,
  // strings without begin or end, strings ending on digits, and stars
  task automatic queue_random_string();
    logic [7:0]  chars[$];
    logic [7:0]  op_letters[8];
    logic [31:0] origin;
    bit          with_begin, with_end;
    int          kind, pick, n_dig;
    op_letters = '{CH_M, CH_EQ, CH_X, CH_I, CH_D, CH_N, CH_S, CH_H};
    kind = $urandom_range(99);
    with_begin = 1'b1;
    with_end = 1'b1;
    origin = ($urandom_range(4) == 0) ? 32'hFFFF_FFFF - $urandom_range(255) : $urandom;
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) chars.insert(chars.size(), 8'($urandom_range(255)));
      with_begin = 1'($urandom_range(1));
      with_end = 1'($urandom_range(1));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        pick = $urandom_range(99);
        n_dig = (pick < 8) ? 0 : (pick < 88) ? $urandom_range(1, 3) :
                (pick < 95) ? $urandom_range(4, 9) : $urandom_range(10, 11);
        for (int k = 0; k < n_dig; k++)
          chars.insert(chars.size(),
                       CH_ZERO + 8'($urandom_range(k == 0 ? 1 : 0, 9)));
        pick = $urandom_range(99);
        if (pick < 4) begin
          chars.insert(chars.size(), CH_P);
        end else begin
          if (pick < 8) chars.insert(chars.size(), 8'($urandom_range(255)));
          chars.insert(chars.size(), op_letters[$urandom_range(7)]);
        end
      end
      if (kind < 20) begin
        chars.insert(chars.size(), CH_STAR);
        repeat ($urandom_range(0, 4))
          chars.insert(chars.size(),
                       $urandom_range(1) ? op_letters[$urandom_range(7)] :
                       CH_ZERO + 8'($urandom_range(9)));
      end else if (kind >= 88) begin
        pick = $urandom_range(2);
        if (pick == 0) with_begin = 1'b0;
        else if (pick == 1) with_end = 1'b0;
        else repeat ($urandom_range(1, 3))
          chars.insert(chars.size(), CH_ZERO + 8'($urandom_range(9)));
      end
    end
    foreach (chars[i])
      queue_char(chars[i], with_begin && i == 0, origin,
                 with_end && i == chars.size() - 1);
    n_strings++;
  endtask

  // Sender: present the next character on the falling edge
  always @(negedge clk) begin
    if (!rst && !offer_held) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_chars.pop_front();
        offer_held = 1'b1;
        s_tvalid <= 1'b1;
        s_tdata  <= {offered.origin, offered.ch};
        s_tuser  <= offered.first;
        s_tlast  <= offered.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a pending hold-off overrides the random stalls
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    res_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        parse_char(offered);
        offer_held = 1'b0;
        n_taken++;
      end
      if (s_tvalid && !s_tready) n_input_stalls++;
      if (m_tvalid && m_tready) begin
        got.kind         = m_tuser;
        got.code         = op_t'(m_tdata[3:0]);
        got.len          = m_tdata[34:4];
        got.read_used    = m_tdata[35];
        got.read_start   = m_tdata[67:36];
        got.ref_used     = m_tdata[68];
        got.ref_start    = m_tdata[100:69];
        got.read_length  = m_tdata[132:101];
        got.match_total  = m_tdata[163:133];
        got.insert_total = m_tdata[194:164];
        got.delete_total = m_tdata[225:195];
        got.clip_total   = m_tdata[256:226];
        if (expected_records.size() == 0) begin
          report_mismatch("unexpected record", {m_tuser, m_tdata[62:0]}, '0);
        end else begin
          want = expected_records.pop_front();
          if (want.kind) n_summaries++;
          else n_op_records++;
          if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
          if (got.code !== want.code) report_mismatch("op_code", got.code, want.code);
          if (got.len !== want.len) report_mismatch("op_len", got.len, want.len);
          if (got.read_used !== want.read_used)
            report_mismatch("read_used", got.read_used, want.read_used);
          if (got.read_start !== want.read_start)
            report_mismatch("read_start", got.read_start, want.read_start);
          if (got.ref_used !== want.ref_used)
            report_mismatch("ref_used", got.ref_used, want.ref_used);
          if (got.ref_start !== want.ref_start)
            report_mismatch("ref_start", got.ref_start, want.ref_start);
          if (got.read_length !== want.read_length)
            report_mismatch("read_length", got.read_length, want.read_length);
          if (got.match_total !== want.match_total)
            report_mismatch("match_total", got.match_total, want.match_total);
          if (got.insert_total !== want.insert_total)
            report_mismatch("insert_total", got.insert_total, want.insert_total);
          if (got.delete_total !== want.delete_total)
            report_mismatch("delete_total", got.delete_total, want.delete_total);
          if (got.clip_total !== want.clip_total)
            report_mismatch("clip_total", got.clip_total, want.clip_total);
        end
      end
    end
  end

  initial begin
    int idle_plan[4];
    int stall_plan[4];
    int target;
    idle_plan  = '{0, 50, 0, 34};
    stall_plan = '{0, 0, 50, 34};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_plan[ph];
      stall_pct = stall_plan[ph];
      if (ph == 0) begin
        // every op, a bare letter, P dropping digits, an ignored character,
        // reference wrap from a high origin, then a star and ignored tail
        queue_text("10M=2X3I1D4N5PS7qH", 32'hFFFF_FFFE);
        queue_text("2M*5M", 32'h0000_0000);
      end
      target = n_queued + 400;
      while (n_queued < target) queue_random_string();
      if (ph == 0) begin
        // hold the output long enough for the block to back up its input
        @(posedge clk);
        hold_left = 300;
      end
      while (pending_chars.size() != 0 || offer_held) @(posedge clk);
    end
    while (expected_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d characters in %0d strings: %0d operation records, %0d summaries.",
             n_taken, n_strings, n_op_records, n_summaries);
    $display("Input stalled %0d cycles under output back-pressure; %0d mismatches.",
             n_input_stalls, n_errors);
    if (n_errors == 0 && expected_records.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d records outstanding.", expected_records.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/csp_pkg.sv
sv/csp_front.sv
sv/csp_queue.sv
sv/csp_back.sv
sv/cigar_string_parser.sv
dv/tb_cigar_string_parser.sv
